// ===== rtl/order_statistic_select_top_macros.svh =====
// Assertion macros shared by the checker.
`ifndef ORDER_STATISTIC_SELECT_TOP_MACROS_SVH
`define ORDER_STATISTIC_SELECT_TOP_MACROS_SVH

// The antecedent implies the consequent in the same cycle.
`define OSS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("order_statistic_select: same-cycle check failed");

// The antecedent implies the consequent in the next cycle.
`define OSS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("order_statistic_select: next-cycle check failed");

`endif

// ===== rtl/oss_pkg.sv =====
package oss_pkg;

    localparam int CAPACITY_DEFAULT   = 1024;
    localparam int VALUE_BITS_DEFAULT = 32;
    localparam int RANK_BITS_DEFAULT  = $clog2(CAPACITY_DEFAULT + 1);

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_SELECT = 1'b1;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_BAD_RANK = 2'd1;
    localparam logic [1:0] STATUS_FULL     = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_INS_NEW,
        S_INS_RD,
        S_INS_EVAL,
        S_SEL_RD,
        S_SEL_LEFT,
        S_SEL_EVAL,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic latch_in;
        logic check;
        logic ins_new;
        logic ins_eval;
        logic rd_left;
        logic sel_eval;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic is_select;
        logic reject;
        logic root_null;
        logic link_null;
        logic sel_done;
        logic out_free;
    } t_dp_stat;

endpackage

// ===== rtl/oss_if.sv =====
interface oss_in_if #(
    parameter int VALUE_BITS = oss_pkg::VALUE_BITS_DEFAULT,
    parameter int RANK_BITS  = oss_pkg::RANK_BITS_DEFAULT
);
    logic                  valid;
    logic                  ready;
    logic                  cmd;
    logic [VALUE_BITS-1:0] value;
    logic [RANK_BITS-1:0]  rank;

    modport source (output valid, output cmd, output value, output rank, input ready);
    modport sink   (input valid, input cmd, input value, input rank, output ready);
endinterface

interface oss_out_if #(
    parameter int VALUE_BITS = oss_pkg::VALUE_BITS_DEFAULT
);
    logic                  valid;
    logic                  ready;
    logic [VALUE_BITS-1:0] result_value;
    logic [1:0]            status;

    modport source (output valid, output result_value, output status, input ready);
    modport sink   (input valid, input result_value, input status, output ready);
endinterface

// ===== rtl/oss_ram.sv =====
module oss_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                       i_clk,
    input  logic                                       i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                           i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                           o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/oss_ctrl.sv =====
module oss_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  oss_pkg::t_dp_stat i_stat,
    output oss_pkg::t_dp_cmd  o_cmd
);

    oss_pkg::t_state r_state;
    oss_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= oss_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            oss_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = oss_pkg::S_CHECK;
                end
            end
            oss_pkg::S_CHECK: begin
                if (i_stat.reject) begin
                    n_state = oss_pkg::S_FINISH;
                end else if (i_stat.is_select) begin
                    n_state = oss_pkg::S_SEL_RD;
                end else begin
                    n_state = oss_pkg::S_INS_NEW;
                end
            end
            oss_pkg::S_INS_NEW: begin
                n_state = i_stat.root_null ? oss_pkg::S_FINISH : oss_pkg::S_INS_RD;
            end
            oss_pkg::S_INS_RD: begin
                n_state = oss_pkg::S_INS_EVAL;
            end
            oss_pkg::S_INS_EVAL: begin
                n_state = i_stat.link_null ? oss_pkg::S_FINISH : oss_pkg::S_INS_RD;
            end
            oss_pkg::S_SEL_RD: begin
                n_state = oss_pkg::S_SEL_LEFT;
            end
            oss_pkg::S_SEL_LEFT: begin
                n_state = oss_pkg::S_SEL_EVAL;
            end
            oss_pkg::S_SEL_EVAL: begin
                n_state = i_stat.sel_done ? oss_pkg::S_FINISH : oss_pkg::S_SEL_RD;
            end
            oss_pkg::S_FINISH: begin
                if (i_stat.out_free) begin
                    n_state = oss_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = oss_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd          = '0;
        o_in_ready     = 1'b0;
        case (r_state)
            oss_pkg::S_IDLE: begin
                o_in_ready     = 1'b1;
                o_cmd.latch_in = i_in_valid;
            end
            oss_pkg::S_CHECK: begin
                o_cmd.check = 1'b1;
            end
            oss_pkg::S_INS_NEW: begin
                o_cmd.ins_new = 1'b1;
            end
            oss_pkg::S_INS_EVAL: begin
                o_cmd.ins_eval = 1'b1;
            end
            oss_pkg::S_SEL_LEFT: begin
                o_cmd.rd_left = 1'b1;
            end
            oss_pkg::S_SEL_EVAL: begin
                o_cmd.sel_eval = 1'b1;
            end
            oss_pkg::S_FINISH: begin
                o_cmd.load_out = i_stat.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

// ===== rtl/oss_dpath.sv =====
module oss_dpath #(
    parameter int CAPACITY   = oss_pkg::CAPACITY_DEFAULT,
    parameter int VALUE_BITS = oss_pkg::VALUE_BITS_DEFAULT
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  oss_pkg::t_dp_cmd                     i_cmd,
    output oss_pkg::t_dp_stat                    o_stat,
    input  logic                                 i_in_cmd,
    input  logic [VALUE_BITS-1:0]                i_in_value,
    input  logic [$clog2(CAPACITY + 1)-1:0]      i_in_rank,
    input  logic                                 i_out_ready,
    output logic                                 o_out_valid,
    output logic [VALUE_BITS-1:0]                o_result_value,
    output logic [1:0]                           o_status
);

    localparam int ADDR_BITS = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int LINK_BITS = $clog2(CAPACITY + 1);
    localparam logic [LINK_BITS-1:0] NULL_LINK = LINK_BITS'(CAPACITY);

    logic                  r_cmd;
    logic [VALUE_BITS-1:0] r_key;
    logic [LINK_BITS-1:0]  r_rank;
    logic [LINK_BITS-1:0]  r_node;
    logic [LINK_BITS-1:0]  r_root;
    logic [LINK_BITS-1:0]  r_stored;
    logic [VALUE_BITS-1:0] r_res_value;
    logic [1:0]            r_res_status;
    logic                  r_out_valid;
    logic [VALUE_BITS-1:0] r_out_value;
    logic [1:0]            r_out_status;

    logic [VALUE_BITS-1:0] value_q;
    logic [LINK_BITS-1:0]  left_q;
    logic [LINK_BITS-1:0]  right_q;
    logic [LINK_BITS-1:0]  count_q;

    logic [ADDR_BITS-1:0]  node_addr;
    logic [ADDR_BITS-1:0]  fresh_addr;
    logic                  go_right;
    logic [LINK_BITS-1:0]  ins_link;
    logic                  link_null;
    logic [LINK_BITS-1:0]  left_size;
    logic [LINK_BITS:0]    left_size_p1;
    logic [LINK_BITS:0]    rank_ext;
    logic                  found;
    logic                  go_left;
    logic [LINK_BITS-1:0]  sel_next;
    logic                  sel_next_null;
    logic                  reject;
    logic                  attach;

    logic                  left_we;
    logic                  right_we;
    logic                  count_we;
    logic [ADDR_BITS-1:0]  link_waddr;
    logic [LINK_BITS-1:0]  link_wdata;
    logic [LINK_BITS-1:0]  count_wdata;
    logic [ADDR_BITS-1:0]  count_raddr;

    assign node_addr  = r_node[ADDR_BITS-1:0];
    assign fresh_addr = r_stored[ADDR_BITS-1:0];

    assign go_right  = $signed(r_key) > $signed(value_q);
    assign ins_link  = go_right ? right_q : left_q;
    assign link_null = (ins_link == NULL_LINK);
    assign attach    = i_cmd.ins_eval && link_null;

    assign left_size     = (left_q == NULL_LINK) ? '0 : count_q;
    assign left_size_p1  = {1'b0, left_size} + (LINK_BITS + 1)'(1);
    assign rank_ext      = {1'b0, r_rank};
    assign found         = (rank_ext == left_size_p1);
    assign go_left       = (rank_ext < left_size_p1);
    assign sel_next      = go_left ? left_q : right_q;
    assign sel_next_null = (sel_next == NULL_LINK);

    always_comb begin
        if (r_cmd == oss_pkg::CMD_SELECT) begin
            reject = (r_rank == '0) || (r_rank > r_stored);
        end else begin
            reject = (r_stored >= NULL_LINK);
        end
    end

    assign left_we     = i_cmd.ins_new || (attach && !go_right);
    assign right_we    = i_cmd.ins_new || (attach && go_right);
    assign count_we    = i_cmd.ins_new || i_cmd.ins_eval;
    assign link_waddr  = i_cmd.ins_new ? fresh_addr : node_addr;
    assign link_wdata  = i_cmd.ins_new ? NULL_LINK : r_stored;
    assign count_wdata = i_cmd.ins_new ? LINK_BITS'(1) : count_q + LINK_BITS'(1);
    assign count_raddr = i_cmd.rd_left ? left_q[ADDR_BITS-1:0] : node_addr;

    oss_ram #(.WIDTH(VALUE_BITS), .DEPTH(CAPACITY)) u_value_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.ins_new),
        .i_waddr (fresh_addr),
        .i_wdata (r_key),
        .i_raddr (node_addr),
        .o_rdata (value_q)
    );

    oss_ram #(.WIDTH(LINK_BITS), .DEPTH(CAPACITY)) u_left_ram (
        .i_clk   (i_clk),
        .i_we    (left_we),
        .i_waddr (link_waddr),
        .i_wdata (link_wdata),
        .i_raddr (node_addr),
        .o_rdata (left_q)
    );

    oss_ram #(.WIDTH(LINK_BITS), .DEPTH(CAPACITY)) u_right_ram (
        .i_clk   (i_clk),
        .i_we    (right_we),
        .i_waddr (link_waddr),
        .i_wdata (link_wdata),
        .i_raddr (node_addr),
        .o_rdata (right_q)
    );

    oss_ram #(.WIDTH(LINK_BITS), .DEPTH(CAPACITY)) u_count_ram (
        .i_clk   (i_clk),
        .i_we    (count_we),
        .i_waddr (link_waddr),
        .i_wdata (count_wdata),
        .i_raddr (count_raddr),
        .o_rdata (count_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_root      <= NULL_LINK;
            r_stored    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.ins_new && (r_root == NULL_LINK)) begin
                r_root <= r_stored;
            end
            if ((i_cmd.ins_new && (r_root == NULL_LINK)) || attach) begin
                r_stored <= r_stored + LINK_BITS'(1);
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_in) begin
            r_cmd        <= i_in_cmd;
            r_key        <= i_in_value;
            r_rank       <= i_in_rank;
            r_res_value  <= '0;
            r_res_status <= oss_pkg::STATUS_OK;
        end
        if (i_cmd.check) begin
            r_node <= r_root;
            if (reject) begin
                r_res_status <= (r_cmd == oss_pkg::CMD_SELECT) ?
                                oss_pkg::STATUS_BAD_RANK : oss_pkg::STATUS_FULL;
            end
        end
        if (i_cmd.ins_eval && !link_null) begin
            r_node <= ins_link;
        end
        if (i_cmd.sel_eval) begin
            if (found) begin
                r_res_value <= value_q;
            end else begin
                r_node <= sel_next;
                if (!go_left) begin
                    r_rank <= r_rank - left_size_p1[LINK_BITS-1:0];
                end
                if (sel_next_null) begin
                    r_res_status <= oss_pkg::STATUS_BAD_RANK;
                end
            end
        end
        if (i_cmd.load_out) begin
            r_out_value  <= r_res_value;
            r_out_status <= r_res_status;
        end
    end

    assign o_stat.is_select = (r_cmd == oss_pkg::CMD_SELECT);
    assign o_stat.reject    = reject;
    assign o_stat.root_null = (r_root == NULL_LINK);
    assign o_stat.link_null = link_null;
    assign o_stat.sel_done  = found || sel_next_null;
    assign o_stat.out_free  = !r_out_valid || i_out_ready;

    assign o_out_valid    = r_out_valid;
    assign o_result_value = r_out_value;
    assign o_status       = r_out_status;

endmodule

// ===== rtl/order_statistic_select_top.sv =====
// Steps: an insert goes through check, a write of the new node and, unless the tree was
// empty, a read and an evaluation per tree level visited; a select through check and, per
// level, a read, a read of the left subtree count and an evaluation; a refused transaction
// goes from check to finish. One transaction at a time, and finish waits for a free output.
// Reset: synchronous, active low; empties the tree, node memories are not cleared.
module order_statistic_select_top #(
    parameter int CAPACITY   = oss_pkg::CAPACITY_DEFAULT,
    parameter int VALUE_BITS = oss_pkg::VALUE_BITS_DEFAULT
) (
    input logic     i_clk,
    input logic     i_rst_n,
    oss_in_if.sink  i_in,
    oss_out_if.source o_out
);

    oss_pkg::t_dp_cmd  dp_cmd;
    oss_pkg::t_dp_stat dp_stat;

    oss_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_stat     (dp_stat),
        .o_cmd      (dp_cmd)
    );

    oss_dpath #(.CAPACITY(CAPACITY), .VALUE_BITS(VALUE_BITS)) u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (dp_cmd),
        .o_stat         (dp_stat),
        .i_in_cmd       (i_in.cmd),
        .i_in_value     (i_in.value),
        .i_in_rank      (i_in.rank),
        .i_out_ready    (o_out.ready),
        .o_out_valid    (o_out.valid),
        .o_result_value (o_out.result_value),
        .o_status       (o_out.status)
    );

endmodule

// ===== rtl/oss_checker.sv =====
`include "order_statistic_select_top_macros.svh"

module oss_checker #(
    parameter int VALUE_BITS = oss_pkg::VALUE_BITS_DEFAULT
) (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_in_valid,
    input logic                  i_in_ready,
    input logic                  i_out_valid,
    input logic                  i_out_ready,
    input logic [VALUE_BITS-1:0] i_out_result_value,
    input logic [1:0]            i_out_status
);

    logic [VALUE_BITS+1:0] out_payload;
    logic                  out_error;
    logic                  status_known;

    assign out_payload  = {i_out_result_value, i_out_status};
    assign out_error    = i_out_valid && (i_out_status != oss_pkg::STATUS_OK);
    assign status_known = (i_out_status == oss_pkg::STATUS_OK) ||
                          (i_out_status == oss_pkg::STATUS_BAD_RANK) ||
                          (i_out_status == oss_pkg::STATUS_FULL);

    // A result that is not taken stays in place.
    `OSS_ASSERT_NEXT(a_out_hold, i_out_valid && !i_out_ready, i_out_valid && $stable(out_payload))

    // Only one transaction is worked on at a time.
    `OSS_ASSERT_NEXT(a_busy_after_accept, i_in_valid && i_in_ready, !i_in_ready)

    // A failed or refused transaction always reports a zero value.
    `OSS_ASSERT_NOW(a_error_zero, out_error, i_out_result_value == '0)

    // The status code is one of the three defined ones.
    `OSS_ASSERT_NOW(a_status_code, i_out_valid, status_known)

endmodule

bind order_statistic_select_top oss_checker #(.VALUE_BITS(VALUE_BITS)) u_oss_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .i_in_valid         (i_in.valid),
    .i_in_ready         (i_in.ready),
    .i_out_valid        (o_out.valid),
    .i_out_ready        (o_out.ready),
    .i_out_result_value (o_out.result_value),
    .i_out_status       (o_out.status)
);

// ===== sim/testbench.sv =====
module testbench;

    localparam int CAPACITY = oss_pkg::CAPACITY_DEFAULT;
    localparam int NIL      = CAPACITY;

    typedef struct packed {
        logic signed [31:0] value;
        logic [1:0]         status;
    } t_answer;

    // Keeps its own copy of the tree and queues the answer due for each request.
    class t_order_stat_tree;
        logic signed [31:0] node_key [CAPACITY];
        int unsigned        left_link [CAPACITY];
        int unsigned        right_link [CAPACITY];
        int unsigned        subtree [CAPACITY];
        int unsigned        root;
        int unsigned        count;
        t_answer            awaited [$];
        int                 failures;

        function new();
            root     = NIL;
            count    = 0;
            failures = 0;
        endfunction

        function t_answer tree_insert(logic signed [31:0] v);
            t_answer     a;
            int unsigned n;
            logic        done;
            a.value  = '0;
            a.status = oss_pkg::STATUS_FULL;
            if (count >= CAPACITY) return a;
            node_key[count]   = v;
            left_link[count]  = NIL;
            right_link[count] = NIL;
            subtree[count]    = 1;
            if (root == NIL) begin
                root = count;
            end else begin
                n    = root;
                done = 1'b0;
                while (!done) begin
                    subtree[n]++;
                    if (v > node_key[n]) begin
                        if (right_link[n] == NIL) begin
                            right_link[n] = count;
                            done = 1'b1;
                        end else begin
                            n = right_link[n];
                        end
                    end else begin
                        if (left_link[n] == NIL) begin
                            left_link[n] = count;
                            done = 1'b1;
                        end else begin
                            n = left_link[n];
                        end
                    end
                end
            end
            count++;
            a.status = oss_pkg::STATUS_OK;
            return a;
        endfunction

        function t_answer tree_select(int unsigned k);
            t_answer     a;
            int unsigned n;
            int unsigned nl;
            logic        done;
            a.value  = '0;
            a.status = oss_pkg::STATUS_BAD_RANK;
            if (k == 0 || k > count) return a;
            n    = root;
            done = 1'b0;
            while (n != NIL && !done) begin
                nl = (left_link[n] != NIL) ? subtree[left_link[n]] : 0;
                if (k == nl + 1) begin
                    a.value  = node_key[n];
                    a.status = oss_pkg::STATUS_OK;
                    done     = 1'b1;
                end else if (k <= nl) begin
                    n = left_link[n];
                end else begin
                    k = k - (nl + 1);
                    n = right_link[n];
                end
            end
            return a;
        endfunction

        function void note_request(logic cmd, logic signed [31:0] value, logic [10:0] rank);
            if (cmd == oss_pkg::CMD_INSERT) begin
                awaited.push_back(tree_insert(value));
            end else begin
                awaited.push_back(tree_select(rank));
            end
        endfunction

        function void check_answer(logic signed [31:0] value, logic [1:0] status);
            t_answer want;
            if (awaited.size() == 0) begin
                $error("result with no outstanding request: result_value %0d, status %0d",
                       value, status);
                failures++;
                return;
            end
            want = awaited.pop_front();
            if (status !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, status);
                failures++;
            end
            if (value !== want.value) begin
                $error("result_value: expected %0d, got %0d", want.value, value);
                failures++;
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    oss_in_if  in_bus ();
    oss_out_if out_bus ();

    order_statistic_select_top DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_bus),
        .o_out   (out_bus)
    );

    t_order_stat_tree tree;
    int               send_idle_pct;
    int               recv_idle_pct;
    int unsigned      stored_planned;

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        out_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Each accepted transaction is recorded on the edge at which it is taken.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (in_bus.valid && in_bus.ready) begin
                tree.note_request(in_bus.cmd, in_bus.value, in_bus.rank);
            end
            if (out_bus.valid && out_bus.ready) begin
                tree.check_answer(out_bus.result_value, out_bus.status);
            end
        end
    end

    task automatic send_request(logic cmd, logic signed [31:0] value, logic [10:0] rank);
        while ($urandom_range(99) < send_idle_pct) begin
            in_bus.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_bus.valid <= 1'b1;
        in_bus.cmd   <= cmd;
        in_bus.value <= value;
        in_bus.rank  <= rank;
        do begin
            @(posedge i_clk);
        end while (!in_bus.ready);
        if (cmd == oss_pkg::CMD_INSERT && stored_planned < CAPACITY) stored_planned++;
    endtask

    task automatic send_random_request();
        logic signed [31:0] v;
        int unsigned        k;
        int unsigned        roll;
        v    = $urandom;
        roll = $urandom_range(99);
        if (roll < 12) begin
            v = $urandom_range(16);
            v = v - 8;
        end else if (roll < 14) begin
            v = 32'h8000_0000;
        end else if (roll < 16) begin
            v = 32'h7fff_ffff;
        end
        if ($urandom_range(99) < 88) begin
            send_request(oss_pkg::CMD_INSERT, v, 11'($urandom_range(1024)));
        end else begin
            roll = $urandom_range(99);
            if (roll < 6) begin
                k = 0;
            end else if (roll < 12) begin
                k = (stored_planned < CAPACITY) ? stored_planned + 1 : CAPACITY;
            end else if (roll < 16 || stored_planned == 0) begin
                k = $urandom_range(1024);
            end else begin
                k = $urandom_range(stored_planned, 1);
            end
            send_request(oss_pkg::CMD_SELECT, v, 11'(k));
        end
    endtask

    initial begin
        tree           = new();
        stored_planned = 0;
        send_idle_pct  = 37;
        recv_idle_pct  = 69;
        in_bus.valid  <= 1'b0;
        in_bus.cmd    <= oss_pkg::CMD_INSERT;
        in_bus.value  <= '0;
        in_bus.rank   <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Empty tree, the value extremes, duplicates, then every rank and the bad ones.
        send_request(oss_pkg::CMD_SELECT, $urandom, 11'd0);
        send_request(oss_pkg::CMD_SELECT, $urandom, 11'd1);
        send_request(oss_pkg::CMD_SELECT, $urandom, 11'd1024);
        send_request(oss_pkg::CMD_INSERT, 32'h7fff_ffff, 11'd1024);
        send_request(oss_pkg::CMD_INSERT, 32'h8000_0000, 11'd0);
        send_request(oss_pkg::CMD_INSERT, 32'h0000_0000, 11'd1023);
        send_request(oss_pkg::CMD_INSERT, 32'hffff_ffff, 11'd5);
        send_request(oss_pkg::CMD_INSERT, 32'd1, 11'd0);
        for (int i = 0; i < 3; i++) begin
            send_request(oss_pkg::CMD_INSERT, 32'd5, 11'($urandom_range(1024)));
        end
        for (int r = 1; r <= 9; r++) begin
            send_request(oss_pkg::CMD_SELECT, $urandom, 11'(r));
        end
        send_request(oss_pkg::CMD_SELECT, 32'hffff_ffff, 11'd0);
        send_request(oss_pkg::CMD_SELECT, 32'h0000_0000, 11'd1024);

        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 37 : (phase == 1) ? 69 : 0;
            recv_idle_pct = (phase == 0) ? 69 : (phase == 1) ? 37 : 0;
            repeat (330) send_random_request();
        end
        in_bus.valid <= 1'b0;
        @(posedge i_clk);

        while (tree.awaited.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        if (tree.failures == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== order_statistic_select_top.f =====
+incdir+rtl
rtl/oss_pkg.sv
rtl/oss_if.sv
rtl/oss_ram.sv
rtl/oss_ctrl.sv
rtl/oss_dpath.sv
rtl/order_statistic_select_top.sv
rtl/oss_checker.sv
sim/testbench.sv
